@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the registry RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define BPAR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked property, active at every edge including reset.
`define BPAR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bpar_pkg.sv @@
// ----------------------------------------------------------------------------
// Breakpoint address registry package
// Request and status codes, controller states and the result word type.
// ----------------------------------------------------------------------------
package bpar_pkg;

    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned HANDLE_W = 16;

    localparam logic [31:0] HASH_MULT = 32'd2654435769;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    localparam logic [1:0] STS_DONE = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_MISS = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } t_state;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle_out;
        logic [1:0]          status;
    } t_result;

endpackage

@@ rtl/core/bpar_if.sv @@
// ----------------------------------------------------------------------------
// Registry channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface bpar_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] address;
    logic [15:0] handle_id;

    modport source (output valid, output req_type, output address, output handle_id,
                    input ready);
    modport sink   (input valid, input req_type, input address, input handle_id,
                    output ready);
endinterface

interface bpar_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [15:0] handle_out;
    logic [1:0]  status;

    modport source (output valid, output hit, output handle_out, output status,
                    input ready);
    modport sink   (input valid, input hit, input handle_out, input status,
                    output ready);
endinterface

@@ rtl/core/breakpoint_address_registry.sv @@
// ----------------------------------------------------------------------------
// Breakpoint address registry
// Hash table from 64-bit code addresses to 16-bit hook handles.
// ----------------------------------------------------------------------------
// A request's bucket row is read from the row memory in the cycle it is
// accepted. In the next cycle the ways are compared, the updated row is written
// back and the result register is loaded; no new request is accepted until
// that is done. A new request is accepted only when the result register is
// empty or its word is taken in that same cycle, so a sink that holds off
// stalls the input. After reset a clearing pass writes every bucket row empty,
// and no request is accepted during it.
// BUCKETS must be a power of two; the bucket is the low bits of address times
// 2654435769.
`include "assert_macros.svh"

module breakpoint_address_registry
    import bpar_pkg::*;
#(
    parameter int unsigned BUCKETS = 64,
    parameter int unsigned WAYS    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpar_req_if.sink          i_req,
    bpar_rsp_if.source        o_rsp
);

    localparam int unsigned BB    = $clog2(BUCKETS);
    localparam int unsigned FW    = $clog2(WAYS + 1);
    localparam int unsigned AWS   = WAYS * ADDR_W;
    localparam int unsigned EWS   = WAYS * (ADDR_W + HANDLE_W);
    localparam int unsigned ROW_W = EWS + FW;

    t_state                  r_state, n_state;
    logic [BB-1:0]           r_clr_idx, n_clr_idx;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out;
    logic [1:0]              r_req_type;
    logic [ADDR_W-1:0]       r_address;
    logic [HANDLE_W-1:0]     r_handle;
    logic [BB-1:0]           r_bucket;

    logic                    in_accept;
    logic                    out_accept;
    logic [BB-1:0]           in_bucket;
    logic                    mem_we;
    logic [BB-1:0]           mem_waddr;
    logic [ROW_W-1:0]        mem_wdata;
    logic [ROW_W-1:0]        mem_rdata;

    logic [FW-1:0]                 rd_fill;
    logic [WAYS-1:0][ADDR_W-1:0]   rd_addr;
    logic [WAYS-1:0][HANDLE_W-1:0] rd_hdl;
    logic                          upd_we;
    logic [FW-1:0]                 w_fill;
    logic [WAYS-1:0][ADDR_W-1:0]   w_addr;
    logic [WAYS-1:0][HANDLE_W-1:0] w_hdl;
    t_result                       upd_result;

    assign in_accept  = i_req.valid && i_req.ready;
    assign out_accept = o_rsp.valid && o_rsp.ready;

    bpar_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_address (i_req.address),
        .o_bucket  (in_bucket)
    );

    bpar_mem #(.DEPTH(BUCKETS), .WIDTH(ROW_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (in_bucket),
        .o_rdata (mem_rdata)
    );

    assign rd_addr = mem_rdata[AWS-1:0];
    assign rd_hdl  = mem_rdata[EWS-1:AWS];
    assign rd_fill = mem_rdata[ROW_W-1:EWS];

    bpar_row_update #(.WAYS(WAYS)) u_update (
        .i_req_type (r_req_type),
        .i_address  (r_address),
        .i_handle   (r_handle),
        .i_fill     (rd_fill),
        .i_addr     (rd_addr),
        .i_hdl      (rd_hdl),
        .o_we       (upd_we),
        .o_fill     (w_fill),
        .o_addr     (w_addr),
        .o_hdl      (w_hdl),
        .o_result   (upd_result)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid && !out_accept;
        i_req.ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_bucket;
        mem_wdata   = {w_fill, w_hdl, w_addr};
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                n_clr_idx = r_clr_idx + BB'(1);
                if (r_clr_idx == BB'(BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // The result register is free by the time this request ends.
                i_req.ready = !r_out_valid || o_rsp.ready;
                if (in_accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                mem_we      = upd_we;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_type <= i_req.req_type;
            r_address  <= i_req.address;
            r_handle   <= i_req.handle_id;
            r_bucket   <= in_bucket;
        end
        if (r_state == ST_BUSY) begin
            r_out <= upd_result;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out.hit;
    assign o_rsp.handle_out = r_out.handle_out;
    assign o_rsp.status     = r_out.status;

    `BPAR_ASSERT(a_busy_out_free, i_clk, i_rst_n, (r_state == ST_BUSY) |-> !r_out_valid, "result register occupied while a request completes")
    `BPAR_ASSERT(a_no_idle_write, i_clk, i_rst_n, mem_we |-> (r_state != ST_IDLE), "row memory written while idle")
    `BPAR_ASSERT(a_result_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == ST_BUSY), "result appeared without a completing request")
    `BPAR_ASSERT(a_fill_bound, i_clk, i_rst_n, (mem_we && (r_state == ST_BUSY)) |-> (w_fill <= FW'(WAYS)), "bucket fill count beyond way count")
    `BPAR_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!r_out_valid && (r_state == ST_CLEAR)), "reset did not clear the controller")

endmodule

@@ rtl/core/bpar_hash.sv @@
// ----------------------------------------------------------------------------
// Bucket hash
// Multiplicative hash of the address reduced to a bucket index.
// ----------------------------------------------------------------------------
module bpar_hash
    import bpar_pkg::*;
#(
    parameter int unsigned BUCKETS = 64
) (
    input  logic [ADDR_W-1:0]          i_address,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);

    localparam int unsigned BB = $clog2(BUCKETS);
    localparam logic [BB-1:0] MULT_LO = HASH_MULT[BB-1:0];

    logic [2*BB-1:0] prod;

    // Only the low bits of the product matter, so only the low bits of both
    // factors take part.
    assign prod     = i_address[BB-1:0] * MULT_LO;
    assign o_bucket = prod[BB-1:0];

endmodule

@@ rtl/core/bpar_mem.sv @@
// ----------------------------------------------------------------------------
// Bucket row memory
// Single-port-write, single-port-read synchronous RAM, one row per bucket.
// ----------------------------------------------------------------------------
module bpar_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 325
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bpar_row_update.sv @@
// ----------------------------------------------------------------------------
// Bucket row update
// Compares the ways of one bucket row and builds the row to write back.
// ----------------------------------------------------------------------------
module bpar_row_update
    import bpar_pkg::*;
#(
    parameter int unsigned WAYS = 4
) (
    input  logic [1:0]                        i_req_type,
    input  logic [ADDR_W-1:0]                 i_address,
    input  logic [HANDLE_W-1:0]               i_handle,
    input  logic [$clog2(WAYS+1)-1:0]         i_fill,
    input  logic [WAYS-1:0][ADDR_W-1:0]       i_addr,
    input  logic [WAYS-1:0][HANDLE_W-1:0]     i_hdl,
    output logic                              o_we,
    output logic [$clog2(WAYS+1)-1:0]         o_fill,
    output logic [WAYS-1:0][ADDR_W-1:0]       o_addr,
    output logic [WAYS-1:0][HANDLE_W-1:0]     o_hdl,
    output t_result                           o_result
);

    localparam int unsigned FW = $clog2(WAYS + 1);
    localparam int unsigned MW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0] match_vec;
    logic [MW-1:0]   match_idx;
    logic            found;
    logic            full;

    // Way 0 is the newest entry, so the lowest matching way wins.
    always_comb begin
        match_idx = '0;
        for (int w = 0; w < WAYS; w++) begin
            match_vec[w] = (FW'(w) < i_fill) && (i_addr[w] == i_address);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match_vec[w]) begin
                match_idx = MW'(w);
            end
        end
    end

    assign found = |match_vec;
    assign full  = (i_fill >= FW'(WAYS));

    always_comb begin
        o_we     = 1'b0;
        o_fill   = i_fill;
        o_addr   = i_addr;
        o_hdl    = i_hdl;
        o_result = '{hit: 1'b0, handle_out: '0, status: STS_DONE};
        case (i_req_type)
            REQ_ADD: begin
                if (full) begin
                    o_result.status = STS_FULL;
                end else begin
                    o_we      = 1'b1;
                    o_fill    = i_fill + FW'(1);
                    o_addr[0] = i_address;
                    o_hdl[0]  = i_handle;
                    for (int w = 1; w < WAYS; w++) begin
                        o_addr[w] = i_addr[w-1];
                        o_hdl[w]  = i_hdl[w-1];
                    end
                end
            end
            REQ_REMOVE: begin
                if (!found) begin
                    o_result.status = STS_MISS;
                end else begin
                    o_we         = 1'b1;
                    o_fill       = i_fill - FW'(1);
                    o_result.hit = 1'b1;
                    // Close the gap: ways above the match shift one way toward way 0.
                    for (int w = 0; w + 1 < WAYS; w++) begin
                        if (MW'(w) >= match_idx) begin
                            o_addr[w] = i_addr[w+1];
                            o_hdl[w]  = i_hdl[w+1];
                        end
                    end
                end
            end
            REQ_FIND: begin
                if (!found) begin
                    o_result.status = STS_MISS;
                end else begin
                    o_result.hit        = 1'b1;
                    o_result.handle_out = i_hdl[match_idx];
                end
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

endmodule

@@ bench/breakpoint_address_registry_tb.sv @@
// ----------------------------------------------------------------------------
// Breakpoint address registry testbench
// Runs a short table of directed requests and then weighted random requests
// that are concentrated on a few hot buckets. A shadow copy of the bucket rows
// predicts each result word the directed table does not give. Sender and
// receiver idle at random; the sink once holds off long so the block stalls.
// ----------------------------------------------------------------------------
module breakpoint_address_registry_tb;
    import bpar_pkg::*;

    localparam int unsigned BUCKETS      = 64;
    localparam int unsigned WAYS         = 4;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 427;
    localparam int unsigned POOL_SIZE    = 32;
    localparam int unsigned HOT_COUNT    = 6;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct {
        logic [63:0] addr;
        logic [15:0] handle;
    } t_slot;

    typedef struct {
        logic [1:0]  req_type;
        logic [63:0] addr;
        logic [15:0] handle;
        bit          typed;
        t_result     want;
    } t_directed;

    logic i_clk;
    logic i_rst_n;

    bpar_req_if req_if ();
    bpar_rsp_if rsp_if ();

    breakpoint_address_registry #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow rows: index 0 of each queue is the newest entry of the bucket.
    t_slot       shadow_rows[BUCKETS][$];
    t_result     pending_results[$];
    int unsigned fail_count = 0;
    int unsigned src_gap_pct;
    int unsigned sink_gap_pct;
    bit          hold_pending = 1'b0;

    logic [63:0] addr_pool[POOL_SIZE];
    int unsigned hot_buckets[HOT_COUNT];
    t_directed   directed_rows[];

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int unsigned bucket_index(logic [63:0] addr);
        logic [63:0] prod;
        prod = addr * 64'(HASH_MULT);
        return int'(prod % BUCKETS);
    endfunction

    // Random upper bits, low bits searched so that the address lands in row b.
    function automatic logic [63:0] addr_in_bucket(int unsigned b);
        logic [63:0] addr;
        addr = {$urandom, $urandom};
        for (int unsigned i = 0; i < BUCKETS; i++) begin
            addr = (addr & ~64'(BUCKETS - 1)) | 64'(i);
            if (bucket_index(addr) == b)
                return addr;
        end
        return addr;
    endfunction

    function automatic t_result registry_apply(logic [1:0] req_type, logic [63:0] addr,
                                               logic [15:0] handle);
        t_result     res;
        int unsigned b;
        int          match;
        res        = '0;
        res.status = STS_DONE;
        b          = bucket_index(addr);
        match      = -1;
        for (int w = 0; w < shadow_rows[b].size(); w++)
            if (match < 0 && shadow_rows[b][w].addr == addr)
                match = w;
        case (req_type)
            REQ_ADD: begin
                if (shadow_rows[b].size() >= WAYS)
                    res.status = STS_FULL;
                else
                    shadow_rows[b].push_front('{addr, handle});
            end
            REQ_REMOVE: begin
                if (match < 0) begin
                    res.status = STS_MISS;
                end else begin
                    shadow_rows[b].delete(match);
                    res.hit = 1'b1;
                end
            end
            REQ_FIND: begin
                if (match < 0) begin
                    res.status = STS_MISS;
                end else begin
                    res.hit        = 1'b1;
                    res.handle_out = shadow_rows[b][match].handle;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offers one request word and returns at the edge that accepts it.
    task automatic offer(input logic [1:0] req_type, input logic [63:0] addr,
                         input logic [15:0] handle, input bit typed, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < src_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= req_type;
        req_if.address   <= addr;
        req_if.handle_id <= handle;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        predicted = registry_apply(req_type, addr, handle);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $error("result word with nothing outstanding: hit %0d handle %0h status %0d",
                   rsp_if.hit, rsp_if.handle_out, rsp_if.status);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            if (rsp_if.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
                fail_count++;
            end
            if (rsp_if.handle_out !== want.handle_out) begin
                $error("handle_out: expected %0h, got %0h", want.handle_out, rsp_if.handle_out);
                fail_count++;
            end
            if (rsp_if.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                fail_count++;
            end
        end
    endtask

    // Receiver: checks accepted result words and picks ready for the next cycle.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                check_result();
            if (hold_pending) begin
                hold_pending = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= sink_gap_pct);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int unsigned counted;
        int unsigned pick;
        logic [1:0]  req_type;
        logic [63:0] addr;

        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= REQ_ADD;
        req_if.address   <= '0;
        req_if.handle_id <= '0;
        src_gap_pct  = 35;
        sink_gap_pct = 53;

        // Bucket 0 gets addresses 0, 64, 128, 192 and 256; all ones lands elsewhere.
        directed_rows = '{
            '{REQ_FIND,   64'd0,  16'h0000, 1'b1, '{1'b0, 16'h0000, STS_MISS}},
            '{REQ_REMOVE, '1,     16'hFFFF, 1'b1, '{1'b0, 16'h0000, STS_MISS}},
            '{REQ_ADD,    64'd0,  16'hFFFF, 1'b1, '{1'b0, 16'h0000, STS_DONE}},
            '{REQ_FIND,   64'd0,  16'h0000, 1'b1, '{1'b1, 16'hFFFF, STS_DONE}},
            '{REQ_ADD,    '1,     16'h0000, 1'b1, '{1'b0, 16'h0000, STS_DONE}},
            '{REQ_FIND,   '1,     16'hFFFF, 1'b1, '{1'b1, 16'h0000, STS_DONE}},
            '{REQ_UNUSED, '1,     16'hFFFF, 1'b1, '{1'b0, 16'h0000, STS_DONE}},
            '{REQ_ADD,    64'd0,  16'h1234, 1'b1, '{1'b0, 16'h0000, STS_DONE}},
            '{REQ_FIND,   64'd0,  16'h0000, 1'b1, '{1'b1, 16'h1234, STS_DONE}},
            '{REQ_REMOVE, 64'd0,  16'h5555, 1'b1, '{1'b1, 16'h0000, STS_DONE}},
            '{REQ_FIND,   64'd0,  16'h0000, 1'b1, '{1'b1, 16'hFFFF, STS_DONE}},
            '{REQ_ADD,    64'd64, 16'hA001, 1'b0, '0},
            '{REQ_ADD,    64'd128, 16'hA002, 1'b0, '0},
            '{REQ_ADD,    64'd192, 16'hA003, 1'b0, '0},
            '{REQ_ADD,    64'd256, 16'hA004, 1'b1, '{1'b0, 16'h0000, STS_FULL}},
            '{REQ_FIND,   64'd256, 16'h0000, 1'b1, '{1'b0, 16'h0000, STS_MISS}},
            '{REQ_REMOVE, 64'd128, 16'h0000, 1'b0, '0},
            '{REQ_FIND,   64'd192, 16'h0000, 1'b0, '0},
            '{REQ_ADD,    64'd256, 16'hA005, 1'b0, '0},
            '{REQ_FIND,   64'd0,   16'h0000, 1'b0, '0},
            '{REQ_REMOVE, 64'd0,   16'h0000, 1'b0, '0},
            '{REQ_REMOVE, 64'd0,   16'h0000, 1'b1, '{1'b0, 16'h0000, STS_MISS}},
            '{REQ_FIND,   64'd64,  16'h0000, 1'b0, '0}
        };

        for (int i = 0; i < HOT_COUNT; i++)
            hot_buckets[i] = $urandom_range(BUCKETS - 1);
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = addr_in_bucket(hot_buckets[$urandom_range(HOT_COUNT - 1)]);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].req_type, directed_rows[i].addr, directed_rows[i].handle,
                  directed_rows[i].typed, directed_rows[i].want);

        // Mostly adds, removes and finds on a small pool of addresses that share a
        // few buckets, so rows fill up and hits are common; the rest is noise.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted >= 2 * RANDOM_ITEMS / 3) begin
                if (src_gap_pct != 0) begin
                    src_gap_pct  = 0;
                    sink_gap_pct = 0;
                    hold_pending = 1'b1;
                end
            end else if (counted >= RANDOM_ITEMS / 3) begin
                src_gap_pct  = 53;
                sink_gap_pct = 35;
            end
            pick = $urandom_range(99);
            if (pick < 5)
                req_type = REQ_UNUSED;
            else if (pick < 45)
                req_type = REQ_ADD;
            else if (pick < 72)
                req_type = REQ_REMOVE;
            else
                req_type = REQ_FIND;
            pick = $urandom_range(99);
            if (pick < 70)
                addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 85)
                addr = addr_in_bucket(hot_buckets[$urandom_range(HOT_COUNT - 1)]);
            else
                addr = {$urandom, $urandom};
            offer(req_type, addr, 16'($urandom), 1'b0, '0);
            counted++;
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
